// ===== rtl/core/ffss_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit slot store package
// Shared widths, default sizes and command and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ffss_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;
	localparam int KEY_BITS_DEF = 48;

	localparam int POS_W     = 5;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_TAKE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/ffss_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_slot_store_with_key_lookup_core.sv =====
// ----------------------------------------------------------------------------
// First-fit slot store with key lookup
// Grid of keyed slots with first-fit placement and search-and-remove by key.
// ----------------------------------------------------------------------------
// Usage: an input item (command, start_row, start_col, key) is taken with
// in_valid and in_ready. A place item writes the key into the first free slot
// in row-major order from the start position and gives no result item. A take
// item searches from slot (0,0) and gives one result item (found, row, col)
// on the out_valid / out_ready channel, clearing the matching slot.
// The scan reads one slot per cycle through the single read port of the slot
// memory and issues no read while it steps from the end of one row to the
// next. One item is worked on at a time and in_ready is low meanwhile.
// After reset a clearing pass empties all MAX_ROWS*MAX_COLS slots; no item is
// taken during it, configuration writes are. Results sit in an output
// register: a new item is taken while a result waits, and a finished take
// waits only if the output register is still full. The rows_in_use and
// cols_in_use registers rows_q and cols_q are written with cfg_we, cfg_addr
// and cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce; both reset to 32.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_slot_store_with_key_lookup_core #(
	parameter int MAX_ROWS = ffss_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = ffss_pkg::MAX_COLS_DEF,
	parameter int KEY_BITS = ffss_pkg::KEY_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ffss_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  wire logic [ffss_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           command,
	input  wire logic [ffss_pkg::POS_W-1:0]     start_row,
	input  wire logic [ffss_pkg::POS_W-1:0]     start_col,
	input  wire logic [KEY_BITS-1:0]            key,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                found,
	output logic      [ffss_pkg::POS_W-1:0]     row,
	output logic      [ffss_pkg::POS_W-1:0]     col
);

	import ffss_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BASE_W = $clog2(DEPTH + 1);
	localparam int DIM_W  = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 1);
	localparam int RC_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int SUM_W  = ((BASE_W > RC_W) ? BASE_W : RC_W) + 1;
	localparam int PROD_W = POS_W + $clog2(MAX_COLS + 1);
	localparam int WORD_W = KEY_BITS + 1;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]    rows_q;
	logic [CFG_W-1:0]    cols_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [RC_W-1:0]     r_q;
	logic [RC_W-1:0]     c_q;
	logic [BASE_W-1:0]   base_q;

	logic                rd_vld_s1;
	logic [POS_W-1:0]    r_s1;
	logic [POS_W-1:0]    c_s1;
	logic [ADDR_W-1:0]   addr_s1;

	logic                res_found_q;
	logic [POS_W-1:0]    res_row_q;
	logic [POS_W-1:0]    res_col_q;
	logic                out_valid_q;
	logic                found_q;
	logic [POS_W-1:0]    row_q;
	logic [POS_W-1:0]    col_q;

	logic [RC_W-1:0]     nr;
	logic [RC_W-1:0]     nc;
	logic                exhausted;
	logic                row_end;
	logic                issue;
	logic [SUM_W-1:0]    addr_sum;
	logic [ADDR_W-1:0]   raddr;
	logic [WORD_W-1:0]   rdata;
	logic                slot_used;
	logic                place_hit;
	logic                take_hit;
	logic                hit;
	logic                scan_end;
	logic                ram_we;
	logic [ADDR_W-1:0]   waddr;
	logic [WORD_W-1:0]   wdata;
	logic [PROD_W-1:0]   start_prod;
	logic                accept;
	logic                post;

	assign nr = (RC_W'(rows_q) > RC_W'(MAX_ROWS)) ? RC_W'(MAX_ROWS) : RC_W'(rows_q);
	assign nc = (RC_W'(cols_q) > RC_W'(MAX_COLS)) ? RC_W'(MAX_COLS) : RC_W'(cols_q);

	assign exhausted = (r_q >= nr);
	assign row_end   = (c_q >= nc);
	assign issue     = (state_q == ST_SCAN) && !exhausted && !row_end;
	assign addr_sum  = SUM_W'(base_q) + SUM_W'(c_q);
	assign raddr     = addr_sum[ADDR_W-1:0];

	assign slot_used = rdata[KEY_BITS];
	assign place_hit = (state_q == ST_SCAN) && rd_vld_s1 && (cmd_q == CMD_PLACE) && !slot_used;
	assign take_hit  = (state_q == ST_SCAN) && rd_vld_s1 && (cmd_q == CMD_TAKE) && slot_used
		&& (rdata[KEY_BITS-1:0] == key_q);
	assign hit       = place_hit || take_hit;
	assign scan_end  = (state_q == ST_SCAN) && (hit || (exhausted && !rd_vld_s1));

	assign ram_we = (state_q == ST_CLEAR) || hit;
	assign waddr  = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign wdata  = (state_q == ST_CLEAR) ? '0 : {place_hit, key_q};

	assign start_prod = PROD_W'(start_row) * PROD_W'(MAX_COLS);

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign post     = (state_q == ST_RESULT) && (!out_valid_q || out_ready);

	ffss_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(32);
			cols_q <= CFG_W'(32);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_ROWS: rows_q <= cfg_wdata;
				CFG_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue && !scan_end;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= (cmd_q == CMD_TAKE) ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (post) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
			if (command == CMD_PLACE) begin
				r_q    <= RC_W'(start_row);
				c_q    <= RC_W'(start_col);
				base_q <= BASE_W'(start_prod);
			end else begin
				r_q    <= '0;
				c_q    <= '0;
				base_q <= '0;
			end
		end else if (issue) begin
			c_q <= c_q + 1'b1;
		end else if ((state_q == ST_SCAN) && !exhausted && row_end) begin
			r_q    <= r_q + 1'b1;
			c_q    <= '0;
			base_q <= base_q + BASE_W'(MAX_COLS);
		end
		if (issue) begin
			r_s1    <= r_q[POS_W-1:0];
			c_s1    <= c_q[POS_W-1:0];
			addr_s1 <= raddr;
		end
		if (scan_end) begin
			res_found_q <= take_hit;
			res_row_q   <= take_hit ? r_s1 : '0;
			res_col_q   <= take_hit ? c_s1 : '0;
		end
		if (post) begin
			found_q <= res_found_q;
			row_q   <= res_row_q;
			col_q   <= res_col_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign row       = row_q;
	assign col       = col_q;

endmodule

`default_nettype wire

// ===== rtl/core/ffss_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit slot store checker
// Port-level properties of the slot store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffss_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic                       command,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       found,
	input wire logic [ffss_pkg::POS_W-1:0] row,
	input wire logic [ffss_pkg::POS_W-1:0] col
);

	import ffss_pkg::*;

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an item was accepted");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (row == '0) && (col == '0))
		else $error("a miss reported a nonzero position");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(row)
			&& $stable(col))
		else $error("a stalled result item changed or vanished");

	// The clearing pass keeps the input closed right after reset.
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !in_ready)
		else $error("an item was offered ready during the clearing pass");

	a_place_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_PLACE) && !out_valid |=> !out_valid)
		else $error("a place item produced a result item");

endmodule

bind first_fit_slot_store_with_key_lookup_core ffss_checker u_ffss_checker (.*);

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// First-fit slot store testbench
// Sends place and take items to the slot store and checks every take result
// against a cycle-free model of the grid kept in the bench. A directed part
// covers key extremes, wrap to the next row, out-of-range starts, duplicate
// keys and register edge values. Random phases then run grids of many shapes
// with random sender gaps and receiver stalls in all but the steady phases.
// ----------------------------------------------------------------------------

module tb;

	import ffss_pkg::*;

	localparam int MAX_ROWS    = MAX_ROWS_DEF;
	localparam int MAX_COLS    = MAX_COLS_DEF;
	localparam int KEY_BITS    = KEY_BITS_DEF;
	localparam int SLOT_COUNT  = MAX_ROWS * MAX_COLS;
	localparam int SCAN_SLACK  = MAX_ROWS * (MAX_COLS + 1) + 8;
	localparam int CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} take_reply_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IDX_W-1:0] cfg_addr;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                command;
	logic [POS_W-1:0]    start_row;
	logic [POS_W-1:0]    start_col;
	logic [KEY_BITS-1:0] key;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic [POS_W-1:0]    row;
	logic [POS_W-1:0]    col;

	logic                slot_used [SLOT_COUNT];
	logic [KEY_BITS-1:0] slot_key [SLOT_COUNT];
	logic [CFG_W-1:0]    grid_rows;
	logic [CFG_W-1:0]    grid_cols;
	take_reply_t         take_replies [$];
	logic [KEY_BITS-1:0] key_pool [8];

	bit steady_flow;
	int error_count;
	int result_count;
	int items_sent;
	int place_count;
	int take_count;
	int hit_count;
	int miss_count;
	int setting_count;
	int cycle_count;

	first_fit_slot_store_with_key_lookup_core #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS),
		.KEY_BITS(KEY_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.start_row(start_row),
		.start_col(start_col),
		.key(key),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.row(row),
		.col(col)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d takes outstanding.",
				cycle_count, take_replies.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (steady_flow)
			return 0;
		return $urandom_range(0, 16);
	endfunction

	function automatic int rows_live();
		return (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
	endfunction

	function automatic int cols_live();
		return (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
	endfunction

	// Updates the grid copy for one accepted item and queues the take reply.
	function automatic void apply_command(logic cmd, logic [POS_W-1:0] sr,
		logic [POS_W-1:0] sc, logic [KEY_BITS-1:0] k);
		int nr;
		int nc;
		int r;
		int c;
		int idx;
		take_reply_t reply;
		nr = rows_live();
		nc = cols_live();
		if (cmd == CMD_PLACE) begin
			place_count++;
			for (r = sr; r < nr; r++) begin
				for (c = (r == sr) ? int'(sc) : 0; c < nc; c++) begin
					idx = r * MAX_COLS + c;
					if (!slot_used[idx]) begin
						slot_used[idx] = 1'b1;
						slot_key[idx] = k;
						return;
					end
				end
			end
			return;
		end
		take_count++;
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				idx = r * MAX_COLS + c;
				if (slot_used[idx] && slot_key[idx] == k) begin
					slot_used[idx] = 1'b0;
					reply.found = 1'b1;
					reply.row = POS_W'(r);
					reply.col = POS_W'(c);
					take_replies.push_back(reply);
					hit_count++;
					return;
				end
			end
		end
		reply = '0;
		take_replies.push_back(reply);
		miss_count++;
	endfunction

	task automatic send_item(input logic cmd, input logic [POS_W-1:0] sr,
		input logic [POS_W-1:0] sc, input logic [KEY_BITS-1:0] k);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		command   <= cmd;
		start_row <= sr;
		start_col <= sc;
		key       <= k;
		do @(posedge clk); while (!in_ready);
		apply_command(cmd, sr, sc, k);
		items_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (take_replies.size() != 0);
	endtask

	// A place item gives no result, so after the last reply the block may
	// still be scanning; wait out one full scan before touching registers.
	task automatic wait_idle();
		hold_until_drained();
		repeat (SCAN_SLACK) @(posedge clk);
	endtask

	task automatic set_grid(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_ROWS;
		cfg_wdata <= rows;
		@(posedge clk);
		grid_rows = rows;
		cfg_addr  <= CFG_COLS;
		cfg_wdata <= cols;
		@(posedge clk);
		grid_cols = cols;
		cfg_we    <= 1'b0;
		setting_count++;
	endtask

	initial begin : reply_checker
		int stall;
		take_reply_t want;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			result_count++;
			if (take_replies.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("Unexpected result item %0d: found=%0d row=%0d col=%0d",
						result_count, found, row, col);
			end else begin
				want = take_replies.pop_front();
				if (found !== want.found || row !== want.row || col !== want.col) begin
					error_count++;
					if (error_count <= 10)
						$display({"Mismatch on result item %0d: expected found=%0d ",
							"row=%0d col=%0d, got found=%0d row=%0d col=%0d"},
							result_count, want.found, want.row, want.col,
							found, row, col);
				end
			end
		end
	end

	task automatic test_directed_placement();
		logic [KEY_BITS-1:0] k_one;
		logic [KEY_BITS-1:0] k_two;
		logic [KEY_BITS-1:0] k_lost;
		logic [KEY_BITS-1:0] k_zero;
		logic [KEY_BITS-1:0] k_full;
		k_one  = 48'h0123_4567_89ab;
		k_two  = 48'hfedc_ba98_7654;
		k_lost = 48'h5a5a_a5a5_5a5a;
		k_zero = '0;
		k_full = '1;
		set_grid(6'd4, 6'd4);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_zero);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_full);
		send_item(CMD_PLACE, 5'd3, 5'd3, k_one);
		// The last slot is taken, so this key falls off the end of the grid.
		send_item(CMD_PLACE, 5'd3, 5'd3, k_two);
		// A start column past the grid skips to column zero of the next row.
		send_item(CMD_PLACE, 5'd2, 5'd31, k_two);
		send_item(CMD_PLACE, 5'd31, 5'd31, k_lost);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_one);
		send_item(CMD_TAKE, 5'd31, 5'd31, k_one);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_one);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_lost);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_zero);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_full);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_two);
	endtask

	task automatic test_grid_registers();
		logic [KEY_BITS-1:0] k_a;
		logic [KEY_BITS-1:0] k_b;
		logic [KEY_BITS-1:0] k_c;
		logic [KEY_BITS-1:0] k_d;
		logic [KEY_BITS-1:0] k_e;
		k_a = 48'h0000_0000_0a0a;
		k_b = 48'h8000_0000_0001;
		k_c = 48'h1111_2222_3333;
		k_d = 48'h4444_5555_6666;
		k_e = 48'h7777_8888_9999;
		wait_idle();
		set_grid(6'd0, 6'd32);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_a);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_a);
		wait_idle();
		set_grid(6'd2, 6'd2);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_a);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_b);
		send_item(CMD_PLACE, 5'd1, 5'd0, k_c);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_d);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_e);
		// Shrinking the grid hides slots but keeps what they hold.
		wait_idle();
		set_grid(6'd1, 6'd1);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_d);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_a);
		send_item(CMD_PLACE, 5'd0, 5'd0, k_a);
		wait_idle();
		set_grid(6'd63, 6'd45);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_d);
		send_item(CMD_PLACE, 5'd31, 5'd31, k_e);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_e);
		send_item(CMD_TAKE, 5'd0, 5'd0, k_a);
	endtask

	task automatic run_random_phase(input logic [CFG_W-1:0] rows,
		input logic [CFG_W-1:0] cols, input int count, input bit steady);
		int i;
		int tries;
		int nr;
		int nc;
		int idx;
		int pick;
		logic cmd;
		logic [POS_W-1:0] sr;
		logic [POS_W-1:0] sc;
		logic [KEY_BITS-1:0] k;
		wait_idle();
		set_grid(rows, cols);
		steady_flow = steady;
		nr = rows_live();
		nc = cols_live();
		for (i = 0; i < count; i++) begin
			if (i == count / 2)
				hold_until_drained();
			cmd = $urandom_range(0, 1) ? CMD_TAKE : CMD_PLACE;
			sr = POS_W'($urandom_range(0, 31));
			sc = POS_W'($urandom_range(0, 31));
			k = KEY_BITS'({$urandom, $urandom});
			if (cmd == CMD_PLACE) begin
				if ($urandom_range(0, 3) == 0)
					k = key_pool[$urandom_range(0, 7)];
				if (nr > 0 && nc > 0 && $urandom_range(0, 6) != 0) begin
					sr = POS_W'($urandom_range(0, nr - 1));
					sc = POS_W'($urandom_range(0, nc - 1));
				end
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 9)
					k = key_pool[$urandom_range(0, 7)];
				if (pick < 7 && nr > 0 && nc > 0) begin
					for (tries = 0; tries < 8; tries++) begin
						idx = $urandom_range(0, nr - 1) * MAX_COLS + $urandom_range(0, nc - 1);
						if (slot_used[idx]) begin
							k = slot_key[idx];
							break;
						end
					end
				end
			end
			send_item(cmd, sr, sc, k);
		end
		steady_flow = 1'b0;
	endtask

	task automatic test_random_traffic();
		run_random_phase(6'd8, 6'd8, 80, 1'b0);
		run_random_phase(6'd1, 6'd1, 40, 1'b0);
		run_random_phase(6'd32, 6'd32, 60, 1'b0);
		run_random_phase(6'd2, 6'd32, 50, 1'b1);
		run_random_phase(6'd32, 6'd1, 50, 1'b0);
		run_random_phase(6'd5, 6'd3, 60, 1'b0);
		run_random_phase(6'd63, 6'd40, 40, 1'b0);
		run_random_phase(6'd4, 6'd4, 80, 1'b1);
		run_random_phase(6'd0, 6'd7, 15, 1'b0);
		run_random_phase(6'd7, 6'd0, 15, 1'b0);
		run_random_phase(6'd3, 6'd9, 60, 1'b0);
	endtask

	initial begin : stimulus
		int i;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_ROWS;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		command   <= CMD_PLACE;
		start_row <= '0;
		start_col <= '0;
		key       <= '0;
		steady_flow = 1'b0;
		grid_rows = 6'd32;
		grid_cols = 6'd32;
		for (i = 0; i < SLOT_COUNT; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
		end
		for (i = 0; i < 8; i++)
			key_pool[i] = KEY_BITS'({$urandom, $urandom});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_placement();
		test_grid_registers();
		test_random_traffic();

		hold_until_drained();
		repeat (SCAN_SLACK) @(posedge clk);
		$display("Covered %0d items: %0d places and %0d takes, %0d hits and %0d misses.",
			items_sent, place_count, take_count, hit_count, miss_count);
		$display("Used %0d grid settings, from empty and single-slot grids to oversized.",
			setting_count);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ffss_pkg.sv
rtl/core/ffss_ram.sv
rtl/core/first_fit_slot_store_with_key_lookup_core.sv
rtl/core/ffss_checker.sv
bench/tb.sv
